// File: rtl/ccc_pkg.sv
package ccc_pkg;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } ccc_kind_t;

  // One classified item as it moves from the conversion pipeline to the counters.
  typedef struct packed {
    ccc_kind_t   kind;
    logic [31:0] load_epoch;
  } ccc_item_t;

  localparam int unsigned CCC_QUEUE_DEPTH = 8;

  localparam logic [15:0] CCC_TPS_RESET    = 16'd1000;
  localparam logic [31:0] CCC_SEC_PER_DAY  = 32'd86400;
  localparam logic [16:0] CCC_SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] CCC_SEC_PER_MIN  = 17'd60;
  localparam logic [11:0] CCC_EPOCH_YEAR   = 12'd1970;
  localparam logic [19:0] CCC_DAYS_PER_YR  = 20'd365;
  localparam logic [12:0] CCC_CENTURY      = 13'd100;
  // Leap years in years 1 through 1969.
  localparam logic [10:0] CCC_LEAPS_1969   = 11'd477;
  // ceil(2^16 / 25): exact quotient by 25 for any 10-bit dividend.
  localparam logic [21:0] CCC_RECIP25      = 22'd2622;

  function automatic logic [8:0] days_before_month(input logic [3:0] midx);
    logic [8:0] d;
    case (midx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/ccc_front.sv
module ccc_front
  import ccc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        kind,
  input  logic [5:0]  second,
  input  logic [5:0]  minute,
  input  logic [4:0]  hour,
  input  logic [4:0]  day_of_month,
  input  logic [3:0]  month_number,
  input  logic [11:0] year_number,
  output logic [1:0]  in_flight,
  output logic        push,
  output ccc_item_t   push_item
);

  // Stage 1: year quotients and time of day.
  logic        v1;
  ccc_kind_t   s1_kind;
  logic [11:0] s1_year;
  logic        s1_year_gt;
  logic [9:0]  s1_q4m;
  logic [5:0]  s1_q100m;
  logic [5:0]  s1_q100y;
  logic [3:0]  s1_midx;
  logic [4:0]  s1_day;
  logic [16:0] s1_tod;

  // Stage 2: day count.
  logic        v2;
  ccc_kind_t   s2_kind;
  logic [31:0] s2_days;
  logic [16:0] s2_tod;

  // Stage 3: epoch seconds.
  logic        v3;
  ccc_kind_t   s3_kind;
  logic [31:0] s3_epoch;

  logic [11:0] year_m1;
  logic [21:0] prod_m;
  logic [21:0] prod_y;
  logic [16:0] tod;
  logic [3:0]  midx;

  assign year_m1 = year_number - 12'd1;
  // floor(n/100) is floor(floor(n/4)/25).
  assign prod_m  = {12'd0, year_m1[11:2]} * CCC_RECIP25;
  assign prod_y  = {12'd0, year_number[11:2]} * CCC_RECIP25;
  assign tod     = 17'(hour) * CCC_SEC_PER_HOUR + 17'(minute) * CCC_SEC_PER_MIN
                 + 17'(second);

  always_comb begin
    if (month_number == 4'd0) begin
      midx = 4'd0;
    end else if (month_number > 4'd12) begin
      midx = 4'd11;
    end else begin
      midx = month_number - 4'd1;
    end
  end

  logic [10:0] leaps;
  logic [19:0] year_days;
  logic [12:0] hund;
  logic        div100;
  logic        is_leap;
  logic [31:0] days;

  assign leaps     = 11'(s1_q4m) - 11'(s1_q100m) + 11'(s1_q100m[5:2]) - CCC_LEAPS_1969;
  assign year_days = 20'(s1_year - CCC_EPOCH_YEAR) * CCC_DAYS_PER_YR + 20'(leaps);
  assign hund      = 13'(s1_q100y) * CCC_CENTURY;
  assign div100    = ({1'b0, s1_year} == hund);
  assign is_leap   = ((s1_year[1:0] == 2'd0) && !div100)
                  || (div100 && (s1_q100y[1:0] == 2'd0));
  assign days      = (s1_year_gt ? 32'(year_days) : 32'd0)
                   + 32'(days_before_month(s1_midx))
                   + 32'(is_leap && (s1_midx >= 4'd2))
                   + 32'(s1_day) - 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
    s1_kind    <= ccc_kind_t'(kind);
    s1_year    <= year_number;
    s1_year_gt <= (year_number > CCC_EPOCH_YEAR);
    s1_q4m     <= year_m1[11:2];
    s1_q100m   <= prod_m[21:16];
    s1_q100y   <= prod_y[21:16];
    s1_midx    <= midx;
    s1_day     <= day_of_month;
    s1_tod     <= tod;

    s2_kind    <= s1_kind;
    s2_days    <= days;
    s2_tod     <= s1_tod;

    s3_kind    <= s2_kind;
    s3_epoch   <= s2_days * CCC_SEC_PER_DAY + 32'(s2_tod);
  end

  assign in_flight            = 2'(v1) + 2'(v2) + 2'(v3);
  assign push                 = v3;
  assign push_item.kind       = s3_kind;
  assign push_item.load_epoch = s3_epoch;

endmodule

// File: rtl/ccc_queue.sv
module ccc_queue
  import ccc_pkg::*;
#(
  parameter int unsigned DEPTH = CCC_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ccc_item_t                push_item,
  input  logic                     pop,
  output logic                     not_empty,
  output ccc_item_t                head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ccc_item_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < ($clog2(DEPTH+1))'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

// File: rtl/ccc_back.sv
module ccc_back
  import ccc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] ticks_per_second,
  input  logic        not_empty,
  input  ccc_item_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_epoch,
  output logic [31:0] out_boot,
  output logic        out_elapsed
);

  logic [15:0] tick_count;
  logic [31:0] boot_counter;
  logic [31:0] epoch_counter;

  logic [16:0] tick_next;
  logic        wrap;
  logic [15:0] tick_count_next;
  logic [31:0] boot_counter_next;
  logic [31:0] epoch_counter_next;

  // A new item moves into the output register when it is empty or being drained.
  assign pop       = not_empty && (!out_valid || out_ready);
  assign tick_next = {1'b0, tick_count} + 17'd1;
  assign wrap      = (head.kind == KIND_TICK) && (tick_next >= {1'b0, ticks_per_second});

  always_comb begin
    tick_count_next    = tick_count;
    boot_counter_next  = boot_counter;
    epoch_counter_next = epoch_counter;
    case (head.kind)
      KIND_TICK: begin
        if (wrap) begin
          tick_count_next    = '0;
          boot_counter_next  = boot_counter + 32'd1;
          epoch_counter_next = epoch_counter + 32'd1;
        end else begin
          tick_count_next = tick_next[15:0];
        end
      end
      KIND_LOAD: begin
        epoch_counter_next = head.load_epoch;
      end
      default: begin
        tick_count_next = tick_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      boot_counter  <= '0;
      epoch_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        tick_count    <= tick_count_next;
        boot_counter  <= boot_counter_next;
        epoch_counter <= epoch_counter_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      out_epoch   <= epoch_counter_next;
      out_boot    <= boot_counter_next;
      out_elapsed <= wrap;
    end
  end

`ifndef SYNTHESIS
  a_load_keeps_boot: assert property (@(posedge clk) disable iff (rst)
    (pop && (head.kind == KIND_LOAD)) |=> ($stable(boot_counter) && $stable(tick_count)))
    else $error("date load disturbed the boot or tick counter");

  a_wrap_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    (pop && wrap) |=> ((tick_count == '0) && out_elapsed))
    else $error("completed second did not clear the tick counter");
`endif

endmodule

// File: rtl/calendar_clock_counter_top.sv
// Channel   Direction  Transaction
// s_axis    in         tick (tuser=0) or calendar date load (tuser=1)
// m_axis    out        epoch and boot seconds, tuser flags a completed second
// cfg       in         ticks per second, 16 bits
//
// One item is accepted per cycle while s_axis_tready is high; a result leaves after
// its item passes the three-stage date conversion pipeline (its multiply of the
// 32-bit day count by 86400), followed by the queue and the counter stage.
// Reset clears both second counters and the tick counter, sets ticks per second
// to 1000 and empties the queue; there is no clearing pass.
// When m_axis_tready is low the queue fills, and s_axis_tready drops once queued
// plus in-flight items reach the queue depth.
module calendar_clock_counter_top
  import ccc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = CCC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
  // month_number[25:22], year_number[37:26], zero fill [39:38]
  input  logic [39:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_seconds[31:0], boot_seconds[63:32]
  output logic [63:0] m_axis_tdata,
  // second_elapsed[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0] ticks_per_second;
  logic        accept;
  logic [1:0]  in_flight;
  logic        push;
  ccc_item_t   push_item;
  logic        pop;
  logic        not_empty;
  ccc_item_t   head;
  logic [CW-1:0] count;
  logic [31:0] out_epoch;
  logic [31:0] out_boot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= CCC_TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_second <= cfg_data;
    end
  end

  // Every item in the conversion pipeline already holds a queue slot.
  assign s_axis_tready = ((CW + 2)'(count) + (CW + 2)'(in_flight)) < (CW + 2)'(QUEUE_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  ccc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (s_axis_tuser),
    .second       (s_axis_tdata[5:0]),
    .minute       (s_axis_tdata[11:6]),
    .hour         (s_axis_tdata[16:12]),
    .day_of_month (s_axis_tdata[21:17]),
    .month_number (s_axis_tdata[25:22]),
    .year_number  (s_axis_tdata[37:26]),
    .in_flight    (in_flight),
    .push         (push),
    .push_item    (push_item)
  );

  ccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .count     (count)
  );

  ccc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .ticks_per_second (ticks_per_second),
    .not_empty        (not_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_epoch        (out_epoch),
    .out_boot         (out_boot),
    .out_elapsed      (m_axis_tuser)
  );

  assign m_axis_tdata = {out_boot, out_epoch};

endmodule

// File: bench/calendar_clock_checker.sv
// Watches the three channels of the calendar clock counter, keeps its own copy of
// the counters and the rate register, and compares every result with the oldest
// predicted reading.
module calendar_clock_checker
  import ccc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] epoch;
    logic [31:0] boot;
    logic        elapsed;
  } clock_reading_t;

  localparam int unsigned MAX_PRINTED = 40;
  localparam int unsigned DAYS_BEFORE[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                              304, 334};

  clock_reading_t expected_readings[$];
  logic [15:0]    rate;
  logic [15:0]    tick_count;
  logic [31:0]    boot_secs;
  logic [31:0]    epoch_secs;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int unsigned leaps_up_to(int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // All sums are 32-bit unsigned, so out-of-range fields wrap as the hardware does.
  function automatic logic [31:0] load_epoch(logic [39:0] d);
    int unsigned sec_v, min_v, hour_v, day_v, mon_v, year_v, days;
    sec_v  = d[5:0];
    min_v  = d[11:6];
    hour_v = d[16:12];
    day_v  = d[21:17];
    mon_v  = d[25:22];
    year_v = d[37:26];
    days   = 0;
    if (year_v > 1970) begin
      days = 365 * (year_v - 1970) + (leaps_up_to(year_v - 1) - leaps_up_to(1969));
    end
    if (mon_v < 1) mon_v = 1;
    if (mon_v > 12) mon_v = 12;
    days += DAYS_BEFORE[mon_v - 1];
    if (mon_v >= 3 && leap_year(year_v)) days += 1;
    days += day_v - 1;
    return days * 86400 + hour_v * 3600 + min_v * 60 + sec_v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    clock_reading_t want;
    logic [16:0]    next_count;
    logic           elapsed;
    if (rst) begin
      expected_readings.delete();
      rate       = CCC_TPS_RESET;
      tick_count = '0;
      boot_secs  = '0;
      epoch_secs = '0;
    end else begin
      if (cfg_valid && cfg_ready) rate = cfg_data;

      // Results are checked before new items are queued, so a result can never be
      // matched against an item accepted on the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with nothing pending, epoch", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[31:0] !== want.epoch)
            report_mismatch("epoch_seconds", m_axis_tdata[31:0], want.epoch);
          if (m_axis_tdata[63:32] !== want.boot)
            report_mismatch("boot_seconds", m_axis_tdata[63:32], want.boot);
          if (m_axis_tuser !== want.elapsed)
            report_mismatch("second_elapsed", 32'(m_axis_tuser), 32'(want.elapsed));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        elapsed = 1'b0;
        if (s_axis_tuser == KIND_TICK) begin
          next_count = {1'b0, tick_count} + 17'd1;
          if (next_count >= {1'b0, rate}) begin
            boot_secs  += 1;
            epoch_secs += 1;
            tick_count = '0;
            elapsed    = 1'b1;
          end else begin
            tick_count = next_count[15:0];
          end
        end else begin
          epoch_secs = load_epoch(s_axis_tdata);
        end
        want = '{epoch: epoch_secs, boot: boot_secs, elapsed: elapsed};
        expected_readings.push_back(want);
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

// File: bench/tb_top.sv
module tb_top;
  import ccc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 65;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = KIND_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          outstanding;
  int unsigned idle_cycles = 0;
  bit          hold_request = 1'b0;
  bit          quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  calendar_clock_counter_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  calendar_clock_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  function automatic logic [39:0] pack_date(int unsigned sec_v, int unsigned min_v,
                                            int unsigned hour_v, int unsigned day_v,
                                            int unsigned mon_v, int unsigned year_v);
    return {2'b00, 12'(year_v), 4'(mon_v), 5'(day_v), 5'(hour_v), 6'(min_v), 6'(sec_v)};
  endfunction

  function automatic logic [39:0] random_bits();
    logic [39:0] d;
    d = 40'({$urandom, $urandom});
    d[39:38] = 2'b00;
    return d;
  endfunction

  // Mostly plausible dates, some just below the 32-bit epoch limit so that ticks
  // wrap the counter, and the rest raw field bits.
  function automatic logic [39:0] random_date();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return pack_date($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                       $urandom_range(1, 31), $urandom_range(1, 12),
                       $urandom_range(1970, 2105));
    end else if (pick == 7) begin
      return pack_date($urandom_range(10, 15), 28, 6, 7, 2, 2106);
    end
    return random_bits();
  endfunction

  task automatic send_item(ccc_kind_t kind, logic [39:0] data);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_rate(logic [15:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, a long hold-off on request, always ready when quiet.
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** calendar_clock_counter_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] phase_rates[5];
    ccc_kind_t   kind;
    phase_rates = '{16'd7, 16'd0, 16'd1, 16'hFFFF, 16'd2};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // At the reset rate of 1000 ticks these ticks complete no second.
    repeat (150) send_item(KIND_TICK, random_bits());
    finish_phase();
    set_rate(16'd1);

    send_item(KIND_LOAD, pack_date(0, 0, 0, 1, 1, 1970));
    send_item(KIND_TICK, '0);
    send_item(KIND_LOAD, pack_date(59, 59, 23, 31, 12, 2105));
    send_item(KIND_LOAD, pack_date(0, 0, 0, 29, 2, 2000));
    send_item(KIND_LOAD, pack_date(0, 0, 0, 1, 3, 2000));
    send_item(KIND_LOAD, pack_date(0, 0, 0, 1, 3, 1900));
    send_item(KIND_LOAD, pack_date(0, 0, 0, 1, 3, 2100));
    send_item(KIND_LOAD, pack_date(30, 15, 12, 1, 3, 2024));
    send_item(KIND_LOAD, pack_date(59, 59, 23, 31, 12, 1969));
    send_item(KIND_LOAD, pack_date(0, 0, 0, 0, 0, 0));
    send_item(KIND_LOAD, pack_date(63, 63, 31, 31, 15, 4095));
    send_item(KIND_LOAD, pack_date(5, 4, 3, 0, 13, 2001));
    send_item(KIND_LOAD, pack_date(0, 0, 0, 15, 0, 1984));
    // Epoch counter one and two seconds below the 32-bit limit, then wrap through zero.
    send_item(KIND_LOAD, pack_date(15, 28, 6, 7, 2, 2106));
    send_item(KIND_TICK, '0);
    send_item(KIND_LOAD, pack_date(14, 28, 6, 7, 2, 2106));
    send_item(KIND_TICK, '1);
    send_item(KIND_TICK, '0);
    finish_phase();

    set_rate(16'hFFFF);
    repeat (6) send_item(KIND_TICK, '0);
    finish_phase();
    // Rate lowered below the running tick count: the next tick completes a second.
    set_rate(16'd3);
    repeat (4) send_item(KIND_TICK, '0);
    finish_phase();

    for (int p = 0; p < 5; p++) begin
      set_rate(phase_rates[p]);
      if (p == 0) hold_request = 1'b1;
      if (p == 4) quiet = 1'b1;
      repeat (PHASE_ITEMS) begin
        kind = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_TICK;
        send_item(kind, (kind == KIND_LOAD) ? random_date() : random_bits());
      end
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** calendar_clock_counter_top: PASSED **");
    end else begin
      $display("** calendar_clock_counter_top: FAILED **");
    end
    $finish;
  end

endmodule
